>>> design/prba_pkg.sv
// Shared constants for the permute/reshape block address generator.
// No dependencies; used by the top level and its port checker.
package prba_pkg;

  localparam int MAX_RANK_DEF   = 4;
  localparam int DIM_BITS_DEF   = 16;
  localparam int INDEX_BITS_DEF = 32;

  localparam int ACC_BITS       = 64;  // width of strides and intermediate sums
  localparam int OUT_BITS       = 32;  // width of the index ports
  localparam int APB_DATA_BITS  = 64;
  localparam int APB_ADDR_BITS  = 6;
  localparam int REG_IDX_BITS   = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_SRC_SHAPE   = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_PERM_ORDER  = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_MID_SHAPE   = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SLICE_START = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_SHAPE  = 3'd4;
  localparam logic [REG_IDX_BITS-1:0] REG_SRC_BASE    = 3'd5;
  localparam logic [REG_IDX_BITS-1:0] REG_DEST_BASE   = 3'd6;

  localparam logic [ACC_BITS-1:0] SHAPE_RESET = 64'h0001_0001_0001_0001;
  localparam logic [7:0]          PERM_RESET  = 8'hE4;

endpackage

>>> design/permute_reshape_block_address.sv
// One beat per cycle unless a stalled output holds the pipeline.
// The depth is set by the bit-per-stage dividers of the two coordinate splits.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and loads register defaults.
// After a write the stride chains settle entry by entry; the entry delay covers that.
// Uses prba_pkg and prba_div.
module permute_reshape_block_address #(
  parameter int MAX_RANK   = prba_pkg::MAX_RANK_DEF,
  parameter int DIM_BITS   = prba_pkg::DIM_BITS_DEF,
  parameter int INDEX_BITS = prba_pkg::INDEX_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [prba_pkg::OUT_BITS-1:0]      in_src_index,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [prba_pkg::OUT_BITS-1:0]      out_dest_index,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [prba_pkg::APB_ADDR_BITS-1:0] paddr,
  input  logic [prba_pkg::APB_DATA_BITS-1:0] pwdata,
  output logic [prba_pkg::APB_DATA_BITS-1:0] prdata,
  output logic                               pready
);

  localparam int AW  = prba_pkg::ACC_BITS;
  localparam int OB  = prba_pkg::OUT_BITS;
  // final sum only needs the bits that reach the port
  localparam int RB  = (INDEX_BITS < OB) ? INDEX_BITS : OB;
  localparam int WB  = (INDEX_BITS > OB) ? INDEX_BITS : OB;
  localparam int PAD = MAX_RANK;
  localparam int LAT = 1 + PAD + 2 * INDEX_BITS + 3 + 2 * AW + 3;

  // ---------------- config registers (APB) ----------------
  logic [AW-1:0] src_shape_r, mid_shape_r, slice_r, dest_shape_r;
  logic [7:0]    perm_r;
  logic [OB-1:0] src_base_r, dest_base_r;
  logic [prba_pkg::REG_IDX_BITS-1:0] reg_idx;
  logic          cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[prba_pkg::APB_ADDR_BITS-1:3];
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_shape_r  <= prba_pkg::SHAPE_RESET;
      perm_r       <= prba_pkg::PERM_RESET;
      mid_shape_r  <= prba_pkg::SHAPE_RESET;
      slice_r      <= '0;
      dest_shape_r <= prba_pkg::SHAPE_RESET;
      src_base_r   <= '0;
      dest_base_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        prba_pkg::REG_SRC_SHAPE:   src_shape_r  <= pwdata;
        prba_pkg::REG_PERM_ORDER:  perm_r       <= pwdata[7:0];
        prba_pkg::REG_MID_SHAPE:   mid_shape_r  <= pwdata;
        prba_pkg::REG_SLICE_START: slice_r      <= pwdata;
        prba_pkg::REG_DEST_SHAPE:  dest_shape_r <= pwdata;
        prba_pkg::REG_SRC_BASE:    src_base_r   <= pwdata[OB-1:0];
        prba_pkg::REG_DEST_BASE:   dest_base_r  <= pwdata[OB-1:0];
        default: ;  // writes past the register list are dropped
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      prba_pkg::REG_SRC_SHAPE:   prdata = src_shape_r;
      prba_pkg::REG_PERM_ORDER:  prdata = AW'(perm_r);
      prba_pkg::REG_MID_SHAPE:   prdata = mid_shape_r;
      prba_pkg::REG_SLICE_START: prdata = slice_r;
      prba_pkg::REG_DEST_SHAPE:  prdata = dest_shape_r;
      prba_pkg::REG_SRC_BASE:    prdata = AW'(src_base_r);
      prba_pkg::REG_DEST_BASE:   prdata = AW'(dest_base_r);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- unpack dims, permutation ----------------
  logic [DIM_BITS-1:0] src_dim [MAX_RANK];
  logic [DIM_BITS-1:0] mid_dim [MAX_RANK];
  logic [DIM_BITS-1:0] slc_dim [MAX_RANK];
  logic [DIM_BITS-1:0] dst_dim [MAX_RANK];
  logic [DIM_BITS-1:0] pdim    [MAX_RANK];
  logic [3:0]          ax      [MAX_RANK];

  // axis entry reduced modulo the rank (entry is at most 3)
  function automatic logic [3:0] axis_mod(input logic [1:0] e);
    logic [3:0] a;
    a = {2'b00, e};
    for (int i = 0; i < 4; i++) begin
      if (a >= 4'(MAX_RANK)) begin
        a = a - 4'(MAX_RANK);
      end
    end
    return a;
  endfunction

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_dim
    localparam int SH = DIM_BITS * (MAX_RANK - 1 - g);
    logic [7:0] ptmp;
    // leading dim sits in the top bits; fields past bit 63 read as zero
    if (SH < AW) begin : g_in
      assign src_dim[g] = DIM_BITS'(src_shape_r >> SH);
      assign mid_dim[g] = DIM_BITS'(mid_shape_r >> SH);
      assign slc_dim[g] = DIM_BITS'(slice_r >> SH);
      assign dst_dim[g] = DIM_BITS'(dest_shape_r >> SH);
    end else begin : g_out
      assign src_dim[g] = '0;
      assign mid_dim[g] = '0;
      assign slc_dim[g] = '0;
      assign dst_dim[g] = '0;
    end
    assign ptmp  = perm_r >> (2 * g);
    assign ax[g] = axis_mod(ptmp[1:0]);
  end

  always_comb begin
    for (int g = 0; g < MAX_RANK; g++) begin
      pdim[g] = '0;
      for (int j = 0; j < MAX_RANK; j++) begin
        if (ax[g] == 4'(j)) begin
          pdim[g] = src_dim[j];
        end
      end
    end
  end

  // ---------------- stride chains ----------------
  // Free running; entry MAX_RANK is the unit stride. The user must keep config
  // static while beats are in flight (not enforced), so stages read these directly.
  logic [AW-1:0] src_st_r [MAX_RANK+1];
  logic [AW-1:0] pst_r    [MAX_RANK+1];
  logic [AW-1:0] mid_st_r [MAX_RANK+1];
  logic [AW-1:0] dst_st_r [MAX_RANK+1];

  always_ff @(posedge clk) begin
    src_st_r[MAX_RANK] <= AW'(1);
    pst_r[MAX_RANK]    <= AW'(1);
    mid_st_r[MAX_RANK] <= AW'(1);
    dst_st_r[MAX_RANK] <= AW'(1);
    for (int g = 0; g < MAX_RANK; g++) begin
      src_st_r[g] <= src_st_r[g+1] * AW'(src_dim[g]);
      pst_r[g]    <= pst_r[g+1]    * AW'(pdim[g]);
      mid_st_r[g] <= mid_st_r[g+1] * AW'(mid_dim[g]);
      dst_st_r[g] <= dst_st_r[g+1] * AW'(dst_dim[g]);
    end
  end

  // ---------------- pipeline control ----------------
  logic             en;
  logic [LAT-1:0]   vld_r;

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- entry: rebase, then wait for strides ----------------
  logic [WB-1:0]         diff;
  logic [INDEX_BITS-1:0] v_r [PAD+1];

  assign diff = WB'(in_src_index) - WB'(src_base_r);

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0] <= diff[INDEX_BITS-1:0];
      for (int k = 1; k <= PAD; k++) begin
        v_r[k] <= v_r[k-1];
      end
    end
  end

  // ---------------- first split: x = (v % st[d]) / st[d+1] ----------------
  logic [INDEX_BITS-1:0] r0 [MAX_RANK];
  logic [INDEX_BITS-1:0] x1 [MAX_RANK];
  logic [INDEX_BITS-1:0] xp [MAX_RANK];

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_split1
    prba_div #(.NB(INDEX_BITS), .DB(AW)) u_rem (
      .clk (clk), .en (en), .a (v_r[PAD]), .d (src_st_r[g]), .q (), .r (r0[g])
    );
    prba_div #(.NB(INDEX_BITS), .DB(AW)) u_quo (
      .clk (clk), .en (en), .a (r0[g]), .d (src_st_r[g+1]), .q (x1[g]), .r ()
    );
  end

  always_comb begin
    for (int g = 0; g < MAX_RANK; g++) begin
      xp[g] = '0;
      for (int j = 0; j < MAX_RANK; j++) begin
        if (ax[g] == 4'(j)) begin
          xp[g] = x1[j];
        end
      end
    end
  end

  // ---------------- permuted join, mod 2^64 ----------------
  // stride split in 32-bit halves: lo product full, hi product low word only
  logic [AW-1:0] pl_r   [MAX_RANK];
  logic [31:0]   ph_r   [MAX_RANK];
  logic [AW-1:0] term_r [MAX_RANK];
  logic [AW-1:0] lin_sum;
  logic [AW-1:0] lin_r;

  always_comb begin
    lin_sum = '0;
    for (int g = 0; g < MAX_RANK; g++) begin
      lin_sum = lin_sum + term_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < MAX_RANK; g++) begin
        pl_r[g]   <= AW'(xp[g]) * AW'(pst_r[g+1][31:0]);
        ph_r[g]   <= 32'(AW'(xp[g]) * AW'(pst_r[g+1][AW-1:32]));
        term_r[g] <= pl_r[g] + {ph_r[g], 32'b0};
      end
      lin_r <= lin_sum;
    end
  end

  // ---------------- second split over the reshaped dims ----------------
  logic [AW-1:0] r2 [MAX_RANK];
  logic [AW-1:0] x2 [MAX_RANK];

  for (genvar g = 0; g < MAX_RANK; g++) begin : g_split2
    prba_div #(.NB(AW), .DB(AW)) u_rem (
      .clk (clk), .en (en), .a (lin_r), .d (mid_st_r[g]), .q (), .r (r2[g])
    );
    prba_div #(.NB(AW), .DB(AW)) u_quo (
      .clk (clk), .en (en), .a (r2[g]), .d (mid_st_r[g+1]), .q (x2[g]), .r ()
    );
  end

  // ---------------- slice offset, destination join, base ----------------
  logic [RB-1:0] y_r [MAX_RANK];
  logic [RB-1:0] m_r [MAX_RANK];
  logic [RB-1:0] out_sum;
  logic [RB-1:0] out_r;

  always_comb begin
    out_sum = dest_base_r[RB-1:0];
    for (int g = 0; g < MAX_RANK; g++) begin
      out_sum = out_sum + m_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int g = 0; g < MAX_RANK; g++) begin
        y_r[g] <= x2[g][RB-1:0] + RB'(slc_dim[g]);
        m_r[g] <= RB'(y_r[g] * dst_st_r[g+1][RB-1:0]);
      end
      out_r <= out_sum;
    end
  end

  assign out_dest_index = OB'(out_r);

endmodule

>>> design/prba_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Standalone; instantiated by permute_reshape_block_address.
module prba_div #(
  parameter int NB = 32,
  parameter int DB = 64
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] a,
  input  logic [DB-1:0] d,
  output logic [NB-1:0] q,
  output logic [NB-1:0] r
);

  localparam int CW = (NB + 1 > DB) ? NB + 1 : DB;

  logic [NB-1:0] rem_r [NB];
  logic [NB-1:0] wrd_r [NB];

  // divisor of zero never subtracts: remainder ends as a, quotient as zero
  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [NB-1:0] rem_in;
    logic [NB-1:0] wrd_in;
    logic [NB:0]   sh;
    logic [CW-1:0] shx;
    logic [CW-1:0] dx;
    logic          take;
    logic [NB-1:0] rem_nxt;
    logic [NB-1:0] wrd_nxt;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign wrd_in = a;
    end else begin : g_next
      assign rem_in = rem_r[k-1];
      assign wrd_in = wrd_r[k-1];
    end

    always_comb begin
      sh      = {rem_in, wrd_in[NB-1]};
      shx     = CW'(sh);
      dx      = CW'(d);
      take    = (d != '0) && (shx >= dx);
      rem_nxt = take ? NB'(shx - dx) : NB'(sh);
      wrd_nxt = {wrd_in[NB-2:0], take};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        wrd_r[k] <= wrd_nxt;
      end
    end
  end

  assign q = wrd_r[NB-1];
  assign r = rem_r[NB-1];

endmodule

>>> design/prba_chk.sv
// Port-level checker for permute_reshape_block_address, with its bind.
// Depends on prba_pkg for the index width.
module prba_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [prba_pkg::OUT_BITS-1:0] out_dest_index
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_index))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat present after reset");

  // with no result waiting the pipeline always takes a beat
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input refused with empty output stage");

  // a stalled output freezes the whole pipeline
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipeline frozen");

endmodule

bind permute_reshape_block_address prba_chk u_prba_chk (.*);
